>>> src/idlm_pkg.sv
// Package for the idle-loop CPU load monitor.
// Holds the shared codes, command and status structs; used by every module.
package idlm_pkg;

   localparam int unsigned PermilleFull = 1000;
   localparam logic [7:0]  ReportReset  = 8'd5;
   localparam logic [31:0] ClockReset   = 32'd480000000;
   localparam int unsigned DivSteps     = 64;

   // Configuration register indexes
   localparam logic CSR_REPORT_WINDOWS = 1'b0;
   localparam logic CSR_SYS_CLOCK_HZ   = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_EMPTY     = 3'd0;
   localparam logic [2:0] ST_NOT_READY = 3'd1;
   localparam logic [2:0] ST_AWAIT     = 3'd2;
   localparam logic [2:0] ST_LOCKED    = 3'd3;
   localparam logic [2:0] ST_SAMPLE    = 3'd4;
   localparam logic [2:0] ST_REPORT    = 3'd5;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_EMPTY,
      OP_NOT_READY,
      OP_LOCK,
      OP_WAIT,
      OP_MUL_LC,
      OP_MUL_RC,
      OP_REPLACE,
      OP_MUL_LK,
      OP_MUL_LS,
      OP_MUL_RS,
      OP_DIV_RCYC,
      OP_DIV_CYC,
      OP_DIV_EXP,
      OP_DIV_SUM,
      OP_DIV_FRM,
      OP_SET_EXP,
      OP_SET_LOAD,
      OP_ACCUM,
      OP_SET_LPS,
      OP_SET_ILPS,
      OP_SET_AVG,
      OP_SET_REPORT,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic cyc_zero;
      logic ready;
      logic delta_zero;
      logic loops_zero;
      logic base_valid;
      logic load_zero;
      logic report_due;
      logic div_busy;
   } dp_status_type;

endpackage

>>> src/idlm_datapath.sv
// Datapath of the load monitor: operand and state registers, one 32x32
// multiplier, one shared 64-bit restoring divider, result and output registers.
// Depends on idlm_pkg.
module idlm_datapath
   import idlm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [95:0]   req_tdata,
   input  logic          req_tuser,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata,
   output logic [127:0]  rsp_tdata,
   output logic [3:0]    rsp_tuser
);

   logic [7:0]  report_windows_ff;
   logic [31:0] sys_clock_hz_ff;

   logic [31:0] in_loops_ff, in_cycles_ff, delta_ff;
   logic        in_ready_ff;

   logic [31:0] ref_loops_ff, ref_cycles_ff, last_frames_ff, frame_sum_ff;
   logic        base_valid_ff;
   logic [7:0]  wait_count_ff, sample_count_ff;
   logic [17:0] load_sum_ff;
   logic [9:0]  load_max_ff;

   logic [63:0] prod_ff, prod_a_ff, exp_ff;

   logic [63:0] div_quo_ff, div_rem_ff, div_den_ff;
   logic [6:0]  div_count_ff;

   logic [2:0]  res_status_ff;
   logic        res_notice_ff;
   logic [9:0]  res_load_ff, res_avg_ff, res_max_ff;
   logic [31:0] res_lps_ff, res_ilps_ff, res_fpw_ff;

   logic [127:0] rsp_data_ff;
   logic [3:0]   rsp_user_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] div_num, div_den;
   logic [64:0] rem_shift;
   logic        rem_ge;
   logic [64:0] rem_diff;
   logic [7:0]  wait_next;
   logic [7:0]  sample_next;
   logic [9:0]  load_new;

   always_comb begin
      case (cmd.op)
         OP_MUL_LC: begin mul_a = in_loops_ff;  mul_b = ref_cycles_ff; end
         OP_MUL_RC: begin mul_a = ref_loops_ff; mul_b = in_cycles_ff;  end
         OP_MUL_LK: begin mul_a = in_loops_ff;  mul_b = 32'(PermilleFull); end
         OP_MUL_LS: begin mul_a = in_loops_ff;  mul_b = sys_clock_hz_ff; end
         default:   begin mul_a = ref_loops_ff; mul_b = sys_clock_hz_ff; end
      endcase
   end

   always_comb begin
      case (cmd.op)
         OP_DIV_CYC: begin div_num = prod_ff; div_den = {32'd0, in_cycles_ff}; end
         OP_DIV_EXP: begin div_num = prod_ff; div_den = exp_ff; end
         OP_DIV_SUM: begin
            div_num = {46'd0, load_sum_ff};
            div_den = {56'd0, sample_count_ff};
         end
         OP_DIV_FRM: begin
            div_num = {32'd0, frame_sum_ff};
            div_den = {56'd0, sample_count_ff};
         end
         default:    begin div_num = prod_ff; div_den = {32'd0, ref_cycles_ff}; end
      endcase
   end

   assign rem_shift   = {div_rem_ff, div_quo_ff[63]};
   assign rem_ge      = rem_shift >= {1'b0, div_den_ff};
   assign rem_diff    = rem_shift - {1'b0, div_den_ff};
   assign wait_next   = wait_count_ff + 8'd1;
   assign sample_next = sample_count_ff + 8'd1;
   assign load_new    = 10'(PermilleFull) - div_quo_ff[9:0];

   always_comb begin
      status.cyc_zero   = in_cycles_ff == 32'd0;
      status.ready      = in_ready_ff;
      status.delta_zero = delta_ff == 32'd0;
      status.loops_zero = in_loops_ff == 32'd0;
      status.base_valid = base_valid_ff;
      status.load_zero  = (exp_ff == 64'd0) || ({32'd0, in_loops_ff} >= exp_ff);
      status.report_due = sample_count_ff >= report_windows_ff;
      status.div_busy   = div_count_ff != 7'd0;
   end

   // Control-like state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         report_windows_ff <= ReportReset;
         sys_clock_hz_ff   <= ClockReset;
         ref_loops_ff      <= '0;
         ref_cycles_ff     <= '0;
         base_valid_ff     <= 1'b0;
         wait_count_ff     <= '0;
         last_frames_ff    <= '0;
         load_sum_ff       <= '0;
         load_max_ff       <= '0;
         frame_sum_ff      <= '0;
         sample_count_ff   <= '0;
         div_count_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REPORT_WINDOWS: report_windows_ff <= csr_wdata[7:0];
               CSR_SYS_CLOCK_HZ:   sys_clock_hz_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (div_count_ff != 7'd0) begin
            div_count_ff <= div_count_ff - 7'd1;
         end
         case (cmd.op)
            OP_CAPTURE: last_frames_ff <= req_tdata[95:64];
            OP_NOT_READY: begin
               base_valid_ff   <= 1'b0;
               wait_count_ff   <= '0;
               load_sum_ff     <= '0;
               load_max_ff     <= '0;
               frame_sum_ff    <= '0;
               sample_count_ff <= '0;
            end
            OP_LOCK: begin
               ref_loops_ff    <= in_loops_ff;
               ref_cycles_ff   <= in_cycles_ff;
               base_valid_ff   <= 1'b1;
               wait_count_ff   <= '0;
               load_sum_ff     <= '0;
               load_max_ff     <= '0;
               frame_sum_ff    <= '0;
               sample_count_ff <= '0;
            end
            OP_WAIT: begin
               wait_count_ff <= (wait_next >= report_windows_ff) ? 8'd0 : wait_next;
            end
            OP_REPLACE: begin
               if (prod_a_ff > prod_ff) begin
                  ref_loops_ff  <= in_loops_ff;
                  ref_cycles_ff <= in_cycles_ff;
               end
            end
            OP_DIV_RCYC, OP_DIV_CYC, OP_DIV_EXP, OP_DIV_SUM, OP_DIV_FRM: begin
               div_count_ff <= (div_den == 64'd0) ? 7'd0 : 7'(DivSteps);
            end
            OP_ACCUM: begin
               load_sum_ff     <= load_sum_ff + {8'd0, res_load_ff};
               if (res_load_ff > load_max_ff) load_max_ff <= res_load_ff;
               frame_sum_ff    <= frame_sum_ff + delta_ff;
               sample_count_ff <= sample_next;
            end
            OP_SET_REPORT: begin
               load_sum_ff     <= '0;
               load_max_ff     <= '0;
               frame_sum_ff    <= '0;
               sample_count_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (div_count_ff != 7'd0) begin
         div_quo_ff <= {div_quo_ff[62:0], rem_ge};
         div_rem_ff <= rem_ge ? rem_diff[63:0] : rem_shift[63:0];
      end
      case (cmd.op)
         OP_CAPTURE: begin
            in_loops_ff   <= req_tdata[31:0];
            in_cycles_ff  <= req_tdata[63:32];
            in_ready_ff   <= req_tuser;
            delta_ff      <= req_tdata[95:64] - last_frames_ff;
            res_status_ff <= ST_EMPTY;
            res_notice_ff <= 1'b0;
            res_load_ff   <= '0;
            res_avg_ff    <= '0;
            res_max_ff    <= '0;
            res_lps_ff    <= '0;
            res_ilps_ff   <= '0;
            res_fpw_ff    <= '0;
         end
         OP_NOT_READY: res_status_ff <= ST_NOT_READY;
         OP_LOCK:      res_status_ff <= ST_LOCKED;
         OP_WAIT: begin
            res_status_ff <= ST_AWAIT;
            res_notice_ff <= wait_next >= report_windows_ff;
         end
         OP_MUL_LC: prod_a_ff <= mul_a * mul_b;
         OP_MUL_RC, OP_MUL_LK, OP_MUL_LS, OP_MUL_RS: prod_ff <= mul_a * mul_b;
         OP_DIV_RCYC, OP_DIV_CYC, OP_DIV_EXP, OP_DIV_SUM, OP_DIV_FRM: begin
            div_quo_ff <= (div_den == 64'd0) ? 64'd0 : div_num;
            div_rem_ff <= '0;
            div_den_ff <= div_den;
         end
         OP_SET_EXP:  exp_ff <= div_quo_ff;
         OP_SET_LOAD: res_load_ff <= load_new;
         OP_ACCUM:    res_status_ff <= ST_SAMPLE;
         OP_SET_LPS:  res_lps_ff <= div_quo_ff[31:0];
         OP_SET_ILPS: res_ilps_ff <= div_quo_ff[31:0];
         OP_SET_AVG: begin
            res_avg_ff <= (div_quo_ff > 64'(PermilleFull)) ? 10'(PermilleFull)
                                                          : div_quo_ff[9:0];
         end
         OP_SET_REPORT: begin
            res_fpw_ff    <= div_quo_ff[31:0];
            res_max_ff    <= load_max_ff;
            res_status_ff <= ST_REPORT;
         end
         OP_PUBLISH: begin
            rsp_data_ff <= {2'b00, res_fpw_ff, res_ilps_ff, res_lps_ff,
                            res_max_ff, res_avg_ff, res_load_ff};
            rsp_user_ff <= {res_notice_ff, res_status_ff};
         end
         default: ;
      endcase
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

>>> src/idlm_controller.sv
// Sequencer of the load monitor: walks one request through the datapath
// operations and owns the request/result handshake. Depends on idlm_pkg.
module idlm_controller
   import idlm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready
);

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE, S_CMP_B, S_REPLACE, S_EXP_MUL, S_EXP_DIV, S_EXP_WAIT,
      S_LOAD_CHK, S_LOAD_DIV, S_LOAD_WAIT, S_ACCUM, S_LPS_MUL, S_LPS_DIV,
      S_LPS_WAIT, S_ILPS_MUL, S_ILPS_DIV, S_ILPS_WAIT, S_RPT_CHK, S_AVG_WAIT,
      S_FPW_DIV, S_FPW_WAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      lock_ff, lock_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      lock_in      = lock_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd.op       = OP_NONE;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin cmd.op = OP_CAPTURE; state_in = S_DECIDE; end
         S_DECIDE: begin
            lock_in = 1'b0;
            if (status.cyc_zero) begin
               cmd.op = OP_EMPTY; state_in = S_DONE;
            end else if (!status.ready) begin
               cmd.op = OP_NOT_READY; state_in = S_DONE;
            end else if (status.delta_zero && !status.loops_zero && !status.base_valid) begin
               cmd.op = OP_LOCK; lock_in = 1'b1; state_in = S_ILPS_MUL;
            end else if (status.delta_zero && !status.loops_zero) begin
               cmd.op = OP_MUL_LC; state_in = S_CMP_B;
            end else if (!status.base_valid) begin
               cmd.op = OP_WAIT; state_in = S_DONE;
            end else begin
               cmd.op = OP_MUL_RC; state_in = S_EXP_DIV;
            end
         end
         S_CMP_B:   begin cmd.op = OP_MUL_RC;   state_in = S_REPLACE;  end
         S_REPLACE: begin cmd.op = OP_REPLACE;  state_in = S_EXP_MUL;  end
         S_EXP_MUL: begin cmd.op = OP_MUL_RC;   state_in = S_EXP_DIV;  end
         S_EXP_DIV: begin cmd.op = OP_DIV_RCYC; state_in = S_EXP_WAIT; end
         S_EXP_WAIT: if (!status.div_busy) begin
            cmd.op = OP_SET_EXP; state_in = S_LOAD_CHK;
         end
         S_LOAD_CHK: begin
            if (status.load_zero) state_in = S_ACCUM;
            else begin cmd.op = OP_MUL_LK; state_in = S_LOAD_DIV; end
         end
         S_LOAD_DIV: begin cmd.op = OP_DIV_EXP; state_in = S_LOAD_WAIT; end
         S_LOAD_WAIT: if (!status.div_busy) begin
            cmd.op = OP_SET_LOAD; state_in = S_ACCUM;
         end
         S_ACCUM:   begin cmd.op = OP_ACCUM;  state_in = S_LPS_MUL;  end
         S_LPS_MUL: begin cmd.op = OP_MUL_LS; state_in = S_LPS_DIV;  end
         S_LPS_DIV: begin cmd.op = OP_DIV_CYC; state_in = S_LPS_WAIT; end
         S_LPS_WAIT: if (!status.div_busy) begin
            cmd.op = OP_SET_LPS; state_in = S_ILPS_MUL;
         end
         S_ILPS_MUL: begin cmd.op = OP_MUL_RS;   state_in = S_ILPS_DIV;  end
         S_ILPS_DIV: begin cmd.op = OP_DIV_RCYC; state_in = S_ILPS_WAIT; end
         S_ILPS_WAIT: if (!status.div_busy) begin
            cmd.op = OP_SET_ILPS; state_in = lock_ff ? S_DONE : S_RPT_CHK;
         end
         S_RPT_CHK: begin
            if (status.report_due) begin cmd.op = OP_DIV_SUM; state_in = S_AVG_WAIT; end
            else state_in = S_DONE;
         end
         S_AVG_WAIT: if (!status.div_busy) begin
            cmd.op = OP_SET_AVG; state_in = S_FPW_DIV;
         end
         S_FPW_DIV: begin cmd.op = OP_DIV_FRM; state_in = S_FPW_WAIT; end
         S_FPW_WAIT: if (!status.div_busy) begin
            cmd.op = OP_SET_REPORT; state_in = S_DONE;
         end
         S_DONE: if (!out_valid_ff || rsp_tready) begin
            cmd.op = OP_PUBLISH; out_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lock_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lock_ff      <= lock_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = out_valid_ff;

endmodule

>>> src/idle_loop_cpu_load_monitor_unit.sv
// Top level of the idle-loop CPU load monitor: controller plus datapath.
// Empty, not-ready and waiting windows take the short path; a baseline lock, a
// sample and a sample with report also wait on the shared divider, which yields
// one quotient bit a cycle.
// Throughput: one request at a time; the next is accepted once the last result
// is in the output register. Reset (synchronous, high) clears baseline and statistics.
module idle_loop_cpu_load_monitor_unit
   import idlm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // loop count, cycle count, frame counter
   input  logic         req_tuser,   // runtime up flag
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // load, avg, max (10 each), loop rate,
                                     // idle loop rate, frames_per_window, pad
   output logic [3:0]   rsp_tuser,   // status (3), wait_notice
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: one datapath operation per cycle, waits on the divider
   idlm_controller u_ctrl (
      .clock, .reset, .status, .cmd,
      .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready
   );

   // Datapath: multiplier, divider, baseline and statistics registers
   idlm_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_tdata, .req_tuser,
      .csr_we, .csr_index, .csr_wdata,
      .rsp_tdata, .rsp_tuser
   );

endmodule

>>> src/idlm_checker.sv
// Port-level checks for the load monitor, bound to the top level.
// Depends on idlm_pkg.
module idlm_checker
   import idlm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [3:0]   rsp_tuser
);

   // Hold a pending result until it is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // Drop the wait notice on anything but an awaiting-baseline result
   a_notice: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == ST_AWAIT)
      else $error("wait notice outside awaiting status");

   // Load only on sample and report results
   a_load: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:0] != 10'd0 |->
         rsp_tuser[2:0] == ST_SAMPLE || rsp_tuser[2:0] == ST_REPORT)
      else $error("load outside sample");

   // Averages and maximum only on reports
   a_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29:10] != 20'd0 |-> rsp_tuser[2:0] == ST_REPORT)
      else $error("report fields outside report");

endmodule

bind idle_loop_cpu_load_monitor_unit idlm_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);

>>> bench/tb_idle_loop_cpu_load_monitor_unit.sv
// Testbench for the idle-loop CPU load monitor: streams measurement windows,
// predicts every result with a scoreboard class and compares field by field.
// Depends on idlm_pkg and idle_loop_cpu_load_monitor_unit.
module tb_idle_loop_cpu_load_monitor_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import idlm_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic        notice;
      logic [9:0]  load;
      logic [9:0]  avg;
      logic [9:0]  maxv;
      logic [31:0] lps;
      logic [31:0] ilps;
      logic [31:0] fpw;
   } load_report_type;

   // Load predictor: holds its own baseline, statistics and register copies.
   class load_scoreboard_type;
      logic [7:0]  rep_windows;
      logic [31:0] clk_hz;
      logic [31:0] base_loops, base_cycles, prev_frames, frm_sum;
      logic        base_ok;
      logic [7:0]  wait_cnt, smp_cnt;
      logic [17:0] lsum;
      logic [9:0]  lmax;
      load_report_type pending[$];
      int errors;
      int reports_seen;

      function new();
         rep_windows = ReportReset;
         clk_hz = ClockReset;
         base_loops = 0; base_cycles = 0; prev_frames = 0;
         base_ok = 0; wait_cnt = 0;
         errors = 0; reports_seen = 0;
         clear_stats();
      endfunction

      function void clear_stats();
         lsum = 0; lmax = 0; frm_sum = 0; smp_cnt = 0;
      endfunction

      function logic [31:0] rate(logic [31:0] lp, logic [31:0] cy);
         logic [63:0] p;
         p = 64'(lp) * 64'(clk_hz);
         if (cy == 0) return 0;
         return 32'(p / 64'(cy));
      endfunction

      function void write_reg(logic idx, logic [31:0] v);
         if (idx == CSR_REPORT_WINDOWS) rep_windows = v[7:0];
         else clk_hz = v;
      endfunction

      // Note one accepted request and queue the result it must produce.
      function void note_request(logic [31:0] loops, logic [31:0] cycles,
                                 logic [31:0] frames, logic ready);
         load_report_type r;
         logic [31:0] delta;
         logic        fresh;
         logic [63:0] expct;
         logic [31:0] ld;
         r = '0;
         delta = frames - prev_frames;
         prev_frames = frames;
         if (cycles == 0) begin
            r.status = ST_EMPTY;
         end else if (!ready) begin
            base_ok = 0; wait_cnt = 0; clear_stats();
            r.status = ST_NOT_READY;
         end else begin
            fresh = 0;
            if (delta == 0 && loops != 0) begin
               fresh = !base_ok;
               if (!base_ok || 64'(loops) * 64'(base_cycles) >
                               64'(base_loops) * 64'(cycles)) begin
                  base_loops = loops; base_cycles = cycles; base_ok = 1;
               end
            end
            if (fresh) begin
               r.ilps = rate(base_loops, base_cycles);
               clear_stats(); wait_cnt = 0;
               r.status = ST_LOCKED;
            end else if (!base_ok) begin
               wait_cnt = wait_cnt + 1;
               if (wait_cnt >= rep_windows) begin
                  r.notice = 1; wait_cnt = 0;
               end
               r.status = ST_AWAIT;
            end else begin
               expct = (base_cycles != 0) ?
                       (64'(base_loops) * 64'(cycles)) / 64'(base_cycles) : 0;
               if (expct == 0 || 64'(loops) >= expct) ld = 0;
               else ld = PermilleFull - 32'((64'(loops) * 64'(PermilleFull)) / expct);
               if (ld > PermilleFull) ld = PermilleFull;
               r.load = ld[9:0];
               lsum = lsum + 18'(ld);
               if (ld[9:0] > lmax) lmax = ld[9:0];
               frm_sum = frm_sum + delta;
               smp_cnt = smp_cnt + 1;
               r.lps = rate(loops, cycles);
               r.ilps = rate(base_loops, base_cycles);
               r.status = ST_SAMPLE;
               if (smp_cnt >= rep_windows) begin
                  if (smp_cnt != 0) begin
                     ld = 32'(lsum) / 32'(smp_cnt);
                     if (ld > PermilleFull) ld = PermilleFull;
                     r.avg = ld[9:0];
                     r.fpw = frm_sum / 32'(smp_cnt);
                  end
                  r.maxv = lmax;
                  clear_stats();
                  r.status = ST_REPORT;
               end
            end
         end
         pending.push_back(r);
      endfunction

      // Compare one accepted result with the oldest prediction.
      function void check_result(load_report_type got);
         load_report_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.status == ST_REPORT) reports_seen++;
         if (got.status !== w.status) mismatch("status", w.status, got.status);
         if (got.notice !== w.notice) mismatch("wait_notice", w.notice, got.notice);
         if (got.load !== w.load) mismatch("window load", w.load, got.load);
         if (got.avg !== w.avg) mismatch("average load", w.avg, got.avg);
         if (got.maxv !== w.maxv) mismatch("max_permille", w.maxv, got.maxv);
         if (got.lps !== w.lps) mismatch("loop rate", w.lps, got.lps);
         if (got.ilps !== w.ilps) mismatch("idle loop rate", w.ilps, got.ilps);
         if (got.fpw !== w.fpw) mismatch("frames_per_window", w.fpw, got.fpw);
      endfunction

      function void mismatch(string fld, logic [31:0] e, logic [31:0] a);
         $display("%0t: %s expected %0d got %0d", $time, fld, e, a);
         errors++;
      endfunction
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [95:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [127:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         csr_we, csr_index;
   logic [31:0]  csr_wdata;

   load_scoreboard_type sb;
   logic [31:0] frame_ctr;   // running frame counter the stimulus keeps
   int          idle_cycles;
   bit          stim_done;
   int          requests;

   idle_loop_cpu_load_monitor_unit i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Send one window; hold valid until the handshake, then drop it.
   task automatic send_window(logic [31:0] loops, logic [31:0] cycles,
                              logic [31:0] frames, logic ready);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_tdata  = {frames, cycles, loops};
      req_tuser  = ready;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(loops, cycles, frames, ready);
      requests++;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // Wait until every prediction is met, then let the block settle.
   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] v);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      sb.write_reg(idx, v);
   endtask

   // Random window: mostly idle or loaded ready windows around a baseline.
   task automatic random_window();
      logic [31:0] loops, cycles;
      logic        ready;
      int k;
      k = $urandom_range(0, 99);
      ready = (k >= 4);
      cycles = (k < 2) ? 0 : ($urandom_range(0, 9) == 0 ? $urandom : 1000 + $urandom_range(0, 200));
      loops = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6000);
      if (k < 50) frame_ctr = frame_ctr + (($urandom_range(0, 9) == 0) ? $urandom
                                           : $urandom_range(1, 40));
      send_window(loops, cycles, frame_ctr, ready);
   endtask

   // Result side: stall at random, check each accepted result.
   initial begin
      int stall;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) stall = 0;
         repeat (stall) @(negedge clock);
         rsp_tready = 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result({rsp_tuser[2:0], rsp_tuser[3], rsp_tdata[9:0],
                          rsp_tdata[19:10], rsp_tdata[29:20], rsp_tdata[61:30],
                          rsp_tdata[93:62], rsp_tdata[125:94]});
         @(negedge clock);
         rsp_tready = 0;
      end
   end

   // Watchdog: count cycles with no handshake on either side.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || stim_done)
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 5000) begin
            $display("idle_loop_cpu_load_monitor_unit verification failed");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      stim_done = 0; requests = 0; frame_ctr = 0;
      req_tvalid = 0; req_tdata = '0; req_tuser = 0;
      csr_we = 0; csr_index = 0; csr_wdata = '0;
      reset = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: empty window, not-ready, waiting with notice, baseline lock,
      // faster baseline replace, full and zero load, report, extreme fields.
      send_window(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1);
      send_window(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      for (int i = 0; i < 6; i++) send_window(100, 1000, 32'hFFFF_FFFF - 32'(i) - 1, 1);
      send_window(5000, 1000, 32'hFFFF_FFF9, 1);                // lock baseline
      send_window(6000, 1000, 32'hFFFF_FFF9, 1);                // faster baseline
      send_window(0, 1000, 32'd5, 1);                            // full load, wraps
      send_window(32'hFFFF_FFFF, 1000, 32'd9, 1);                // zero load
      send_window(3000, 32'hFFFF_FFFF, 32'd20, 1);
      send_window(1, 1, 32'd21, 1);                              // smallest nonzero window
      send_window(3000, 1000, 32'd40, 1);
      send_window(4500, 1000, 32'd41, 1);
      send_window(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd41, 1);      // idle, slower
      send_window(0, 32'hFFFF_FFFF, 32'd41, 0);
      frame_ctr = 41;
      drain();

      // Several register settings, extremes included; random windows in each.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_csr(CSR_REPORT_WINDOWS, 1); write_csr(CSR_SYS_CLOCK_HZ, 1); end
            1: begin write_csr(CSR_REPORT_WINDOWS, 255);
                     write_csr(CSR_SYS_CLOCK_HZ, 32'hFFFF_FFFF); end
            2: begin write_csr(CSR_REPORT_WINDOWS, 0); write_csr(CSR_SYS_CLOCK_HZ, $urandom); end
            3: write_csr(CSR_REPORT_WINDOWS, 8'hAA);
            4: write_csr(CSR_REPORT_WINDOWS, 8'h55);
            default: begin write_csr(CSR_REPORT_WINDOWS, $urandom_range(2, 8));
                           write_csr(CSR_SYS_CLOCK_HZ, ClockReset); end
         endcase
         repeat (325) random_window();
         drain();
      end

      stim_done = 1;
      $display("Run covered %0d windows under six register settings, %0d reports.",
               requests, sb.reports_seen);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("idle_loop_cpu_load_monitor_unit verification clean");
      else
         $display("idle_loop_cpu_load_monitor_unit verification failed");
      $finish;
   end
endmodule
